// ----- rtl/lfu_frequency_table_macros.svh -----
// Assertion macros for the LFU frequency table.
// Included by the top level; needs no other file.
`ifndef LFU_FREQUENCY_TABLE_MACROS_SVH
`define LFU_FREQUENCY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/lfu_pkg.sv -----
// Package for the LFU frequency table: sizes, codes and the state type.
// Used by the interfaces and by the top level lfu_frequency_table.
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BITS = 64;
	localparam int COUNT_BITS = 32;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

	localparam int IN_KEY_W = 64;
	localparam int SLOT_W = 6;
	localparam int OUT_COUNT_W = 32;
	localparam int OUTCOME_W = 2;

	localparam int LIMIT_BITS = 32;
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 32'd65535;
	localparam int CMP_W = ((COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS) + 1;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_COUNT_LIMIT = 1'b0;

	localparam logic [OUTCOME_W-1:0] OUT_HIT = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_CLEARED = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd2;
	localparam logic [OUTCOME_W-1:0] OUT_EVICTED = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_CLEAR,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/lfu_event_if.sv -----
// Input channel of the LFU frequency table: one executed-file key per transaction.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfu_event_if;
	logic valid;
	logic ready;
	logic [lfu_pkg::IN_KEY_W-1:0] item_key;

	modport source (output valid, output item_key, input ready);
	modport sink (input valid, input item_key, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_result_if.sv -----
// Result channel of the LFU frequency table: one result per event transaction.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfu_result_if;
	logic valid;
	logic ready;
	logic [lfu_pkg::OUTCOME_W-1:0] outcome;
	logic [lfu_pkg::SLOT_W-1:0] slot;
	logic [lfu_pkg::OUT_COUNT_W-1:0] new_count;
	logic [lfu_pkg::IN_KEY_W-1:0] evicted_key;
	logic [lfu_pkg::OUT_COUNT_W-1:0] evicted_count;

	modport source (output valid, output outcome, output slot, output new_count,
		output evicted_key, output evicted_count, input ready);
	modport sink (input valid, input outcome, input slot, input new_count,
		input evicted_key, input evicted_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfu_frequency_table.sv -----
// LFU frequency table: key lookup, count update, free-slot insert and least-count eviction.
// Depends on lfu_pkg, lfu_event_if, lfu_result_if, lfu_ram and the macro header.
// A new event is taken only in the idle state, so it waits until the last one is through;
// the scan reads one occupied slot per cycle, and a clear adds a walk over all 64 slots.
// The result passes from the decide registers into the output register and holds there until taken.
// Reset empties the table at once through the fill count; no memory sweep follows reset.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_frequency_table_macros.svh"

module lfu_frequency_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [lfu_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [lfu_pkg::APB_DATA_W-1:0]  pwdata,
	output      logic [lfu_pkg::APB_DATA_W-1:0]  prdata,
	output      logic                            pready,
	lfu_event_if.sink                            evt,
	lfu_result_if.source                         res
);

	lfu_pkg::state_t state_q, state_d;

	logic [lfu_pkg::LIMIT_BITS-1:0] limit_q;
	logic [lfu_pkg::OCC_W-1:0]      occ_q;
	logic [lfu_pkg::OCC_W-1:0]      issue_q;
	logic [lfu_pkg::IDX_W-1:0]      clr_q;
	logic [lfu_pkg::KEY_BITS-1:0]   key_q;

	logic                           pend_s1;
	logic [lfu_pkg::IDX_W-1:0]      slot_s1;

	logic                           hit_q;
	logic [lfu_pkg::IDX_W-1:0]      hit_slot_q;
	logic [lfu_pkg::COUNT_BITS-1:0] hit_cnt_q;
	logic                           min_found_q;
	logic [lfu_pkg::IDX_W-1:0]      min_slot_q;
	logic [lfu_pkg::COUNT_BITS-1:0] min_cnt_q;
	logic [lfu_pkg::KEY_BITS-1:0]   min_key_q;

	logic [lfu_pkg::OUTCOME_W-1:0]   res_outcome_q;
	logic [lfu_pkg::SLOT_W-1:0]      res_slot_q;
	logic [lfu_pkg::OUT_COUNT_W-1:0] res_count_q;
	logic [lfu_pkg::IN_KEY_W-1:0]    res_ekey_q;
	logic [lfu_pkg::OUT_COUNT_W-1:0] res_ecnt_q;

	logic                            out_valid_q;
	logic [lfu_pkg::OUTCOME_W-1:0]   out_outcome_q;
	logic [lfu_pkg::SLOT_W-1:0]      out_slot_q;
	logic [lfu_pkg::OUT_COUNT_W-1:0] out_count_q;
	logic [lfu_pkg::IN_KEY_W-1:0]    out_ekey_q;
	logic [lfu_pkg::OUT_COUNT_W-1:0] out_ecnt_q;

	logic [lfu_pkg::KEY_BITS-1:0]   key_rd;
	logic [lfu_pkg::COUNT_BITS-1:0] cnt_rd;
	logic                           key_we;
	logic                           cnt_we;
	logic [lfu_pkg::IDX_W-1:0]      wr_addr;
	logic [lfu_pkg::COUNT_BITS-1:0] cnt_wdata;
	logic                           rd_en;

	logic cfg_wr;
	logic accept;
	logic scan_issue;
	logic scan_done;
	logic occ_full;
	logic key_match;
	logic min_upd;
	logic out_free;
	logic load_out;

	logic                           cnt_max;
	logic [lfu_pkg::CMP_W-1:0]      cnt_inc_cmp;
	logic [lfu_pkg::CMP_W-1:0]      limit_cmp;
	logic [lfu_pkg::COUNT_BITS-1:0] cnt_next;
	logic                           dec_clear;
	logic                           dec_insert;
	logic [lfu_pkg::OUTCOME_W-1:0]  dec_outcome;
	logic [lfu_pkg::IDX_W-1:0]      dec_slot;
	logic [lfu_pkg::COUNT_BITS-1:0] dec_count;
	logic [lfu_pkg::KEY_BITS-1:0]   dec_ekey;
	logic [lfu_pkg::COUNT_BITS-1:0] dec_ecnt;

	logic [lfu_pkg::IDX_W+lfu_pkg::SLOT_W-1:0]           slot_wide;
	logic [lfu_pkg::COUNT_BITS+lfu_pkg::OUT_COUNT_W-1:0] count_wide;
	logic [lfu_pkg::COUNT_BITS+lfu_pkg::OUT_COUNT_W-1:0] ecnt_wide;
	logic [lfu_pkg::KEY_BITS+lfu_pkg::IN_KEY_W-1:0]      ekey_wide;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lfu_pkg::REG_COUNT_LIMIT);
	assign prdata = (paddr[2] == lfu_pkg::REG_COUNT_LIMIT) ? limit_q : '0;

	assign accept     = evt.valid && evt.ready;
	assign occ_full   = (occ_q == lfu_pkg::OCC_W'(lfu_pkg::TABLE_ENTRIES));
	assign scan_issue = (state_q == lfu_pkg::ST_SCAN) && (issue_q != occ_q);
	assign scan_done  = (state_q == lfu_pkg::ST_SCAN) && (issue_q == occ_q) && !pend_s1;
	assign key_match  = pend_s1 && (key_rd == key_q);
	assign min_upd    = pend_s1 && (!min_found_q || (cnt_rd < min_cnt_q));
	assign out_free   = !out_valid_q || res.ready;
	assign load_out   = (state_q == lfu_pkg::ST_RESULT) && out_free;

	// Count update and the clear-all condition, on a widened compare.
	assign cnt_max     = (hit_cnt_q == '1);
	assign cnt_inc_cmp = lfu_pkg::CMP_W'(hit_cnt_q) + lfu_pkg::CMP_W'(1);
	assign limit_cmp   = lfu_pkg::CMP_W'(limit_q);
	assign dec_clear   = hit_q && !cnt_max && (cnt_inc_cmp == limit_cmp);
	assign cnt_next    = cnt_max ? hit_cnt_q : hit_cnt_q + lfu_pkg::COUNT_BITS'(1);
	assign dec_insert  = !hit_q && !occ_full;

	always_comb begin
		if (hit_q && dec_clear) begin
			dec_outcome = lfu_pkg::OUT_CLEARED;
			dec_slot    = hit_slot_q;
			dec_count   = '0;
		end else if (hit_q) begin
			dec_outcome = lfu_pkg::OUT_HIT;
			dec_slot    = hit_slot_q;
			dec_count   = cnt_next;
		end else if (dec_insert) begin
			dec_outcome = lfu_pkg::OUT_INSERTED;
			dec_slot    = occ_q[lfu_pkg::IDX_W-1:0];
			dec_count   = lfu_pkg::COUNT_BITS'(1);
		end else begin
			dec_outcome = lfu_pkg::OUT_EVICTED;
			dec_slot    = min_slot_q;
			dec_count   = lfu_pkg::COUNT_BITS'(1);
		end
	end

	assign dec_ekey   = (!hit_q && !dec_insert) ? min_key_q : '0;
	assign dec_ecnt   = (!hit_q && !dec_insert) ? min_cnt_q : '0;
	assign slot_wide  = {{lfu_pkg::SLOT_W{1'b0}}, dec_slot};
	assign count_wide = {{lfu_pkg::OUT_COUNT_W{1'b0}}, dec_count};
	assign ecnt_wide  = {{lfu_pkg::OUT_COUNT_W{1'b0}}, dec_ecnt};
	assign ekey_wide  = {{lfu_pkg::IN_KEY_W{1'b0}}, dec_ekey};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (evt.valid) begin
					state_d = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = lfu_pkg::ST_DECIDE;
				end
			end
			lfu_pkg::ST_DECIDE: begin
				state_d = dec_clear ? lfu_pkg::ST_CLEAR : lfu_pkg::ST_RESULT;
			end
			lfu_pkg::ST_CLEAR: begin
				if (clr_q == lfu_pkg::IDX_W'(lfu_pkg::TABLE_ENTRIES - 1)) begin
					state_d = lfu_pkg::ST_RESULT;
				end
			end
			lfu_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = lfu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lfu_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory controls and handshake outputs.
	always_comb begin
		evt.ready = 1'b0;
		key_we    = 1'b0;
		cnt_we    = 1'b0;
		wr_addr   = dec_slot;
		cnt_wdata = dec_count;
		rd_en     = 1'b0;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				evt.ready = 1'b1;
			end
			lfu_pkg::ST_SCAN: begin
				rd_en = scan_issue;
			end
			lfu_pkg::ST_DECIDE: begin
				key_we = !hit_q;
				cnt_we = !dec_clear;
			end
			lfu_pkg::ST_CLEAR: begin
				cnt_we    = 1'b1;
				wr_addr   = clr_q;
				cnt_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	lfu_ram #(
		.WIDTH (lfu_pkg::KEY_BITS),
		.DEPTH (lfu_pkg::TABLE_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (issue_q[lfu_pkg::IDX_W-1:0]),
		.rdata (key_rd)
	);

	lfu_ram #(
		.WIDTH (lfu_pkg::COUNT_BITS),
		.DEPTH (lfu_pkg::TABLE_ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (wr_addr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (issue_q[lfu_pkg::IDX_W-1:0]),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfu_pkg::ST_IDLE;
			limit_q     <= lfu_pkg::LIMIT_RESET;
			occ_q       <= '0;
			issue_q     <= '0;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			min_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				limit_q <= pwdata[lfu_pkg::LIMIT_BITS-1:0];
			end
			if (accept) begin
				issue_q     <= '0;
				pend_s1     <= 1'b0;
				hit_q       <= 1'b0;
				min_found_q <= 1'b0;
			end
			if (state_q == lfu_pkg::ST_SCAN) begin
				pend_s1 <= scan_issue;
				if (scan_issue) begin
					issue_q <= issue_q + lfu_pkg::OCC_W'(1);
				end
				if (key_match) begin
					hit_q <= 1'b1;
				end
				if (min_upd) begin
					min_found_q <= 1'b1;
				end
			end
			if (state_q == lfu_pkg::ST_DECIDE) begin
				clr_q <= '0;
				if (dec_insert) begin
					occ_q <= occ_q + lfu_pkg::OCC_W'(1);
				end
			end
			if (state_q == lfu_pkg::ST_CLEAR) begin
				clr_q <= clr_q + lfu_pkg::IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= evt.item_key[lfu_pkg::KEY_BITS-1:0];
		end
		slot_s1 <= issue_q[lfu_pkg::IDX_W-1:0];
		if (key_match && !hit_q) begin
			hit_slot_q <= slot_s1;
			hit_cnt_q  <= cnt_rd;
		end
		if (min_upd) begin
			min_slot_q <= slot_s1;
			min_cnt_q  <= cnt_rd;
			min_key_q  <= key_rd;
		end
		if (state_q == lfu_pkg::ST_DECIDE) begin
			res_outcome_q <= dec_outcome;
			res_slot_q    <= slot_wide[lfu_pkg::SLOT_W-1:0];
			res_count_q   <= count_wide[lfu_pkg::OUT_COUNT_W-1:0];
			res_ekey_q    <= ekey_wide[lfu_pkg::IN_KEY_W-1:0];
			res_ecnt_q    <= ecnt_wide[lfu_pkg::OUT_COUNT_W-1:0];
		end
		if (load_out) begin
			out_outcome_q <= res_outcome_q;
			out_slot_q    <= res_slot_q;
			out_count_q   <= res_count_q;
			out_ekey_q    <= res_ekey_q;
			out_ecnt_q    <= res_ecnt_q;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.outcome       = out_outcome_q;
	assign res.slot          = out_slot_q;
	assign res.new_count     = out_count_q;
	assign res.evicted_key   = out_ekey_q;
	assign res.evicted_count = out_ecnt_q;

	`LFU_ASSERT_NEXT(a_accept_starts_scan, clk, arst_n, accept, state_q == lfu_pkg::ST_SCAN, "accepted event did not start a scan")
	`LFU_ASSERT_IMP(a_evict_only_when_full, clk, arst_n, res.valid && (res.outcome == lfu_pkg::OUT_EVICTED), occ_full, "eviction reported while the table had a free slot")
	`LFU_ASSERT_NEXT(a_insert_grows_occ, clk, arst_n, (state_q == lfu_pkg::ST_DECIDE) && dec_insert, occ_q == $past(occ_q) + lfu_pkg::OCC_W'(1), "insert did not grow the occupancy")

endmodule

`default_nettype wire

// ----- rtl/lfu_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
